/* sv/piecewise_linear_table_generator_defines.svh */
// assertion macros for the line segment table generator
`ifndef PIECEWISE_LINEAR_TABLE_GENERATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PLTG_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pltg assertion failed");
// next-cycle implication
`define PLTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pltg assertion failed");
`else
`define PLTG_ASSERT(lbl, ante, cons)
`define PLTG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/pltg_pkg.sv */
package pltg_pkg;

  // default sizes
  localparam int MAX_POINTS_DEF = 16;
  localparam int INDEX_BITS_DEF = 16;

  // field widths
  localparam int CMD_W   = 1;
  localparam int SLOT_W  = 4;
  localparam int VAL_W   = 16;
  localparam int LEN_W   = 17;
  localparam int IDX_W   = 16;
  localparam int CNT_W   = 4;
  localparam int TS_W    = 17;
  localparam int STAT_W  = 2;
  localparam int PROD_W  = VAL_W + LEN_W;

  // input tdata layout, lowest bit first
  localparam int SLOT_LSB = 0;
  localparam int VAL_LSB  = SLOT_LSB + SLOT_W;
  localparam int LEN_LSB  = VAL_LSB + VAL_W;
  localparam int IDX_LSB  = LEN_LSB + LEN_W;
  localparam int S_DATA_W = ((IDX_LSB + IDX_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((VAL_W + 7) / 8) * 8;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TS_W;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE    = 2'd1;
  localparam logic [CNT_W-1:0] SEGMENT_COUNT_RST = 4'd1;
  localparam logic [TS_W-1:0]  TABLE_SIZE_RST    = 17'd1024;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // restoring divider, one quotient bit per step
  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_SUM   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_FETCH    = 4'd0,
    S_ROUTE    = 4'd1,
    S_PRIME    = 4'd2,
    S_SUM      = 4'd3,
    S_CHECK    = 4'd4,
    S_SPLIT    = 4'd5,
    S_WALK     = 4'd6,
    S_DIFF     = 4'd7,
    S_MUL      = 4'd8,
    S_DIV_INIT = 4'd9,
    S_DIV      = 4'd10,
    S_FIN      = 4'd11,
    S_LAST     = 4'd12,
    S_EMIT     = 4'd13
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_FETCH, OP_NEXT, OP_SUM, OP_CHECK, OP_WALK,
    OP_DIFF, OP_MUL, OP_DIV_INIT, OP_DIV, OP_FIN, OP_LAST
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_IN_ACC, C_LOAD, C_N_ZERO, C_J_EQ_N,
    C_ERR, C_LAST, C_FOUND, C_DIV_LAST, C_OUT_FREE
  } cond_t;

  // control word: jump to target when cond holds, else hold or advance
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  hold;
  } ucode_t;

  // microprogram
  function automatic ucode_t ucode(input step_t pc);
    ucode_t w;
    case (pc)
      S_FETCH:    w = '{OP_FETCH,    C_IN_ACC,   S_ROUTE,  1'b1};
      S_ROUTE:    w = '{OP_NOP,      C_LOAD,     S_EMIT,   1'b0};
      S_PRIME:    w = '{OP_NEXT,     C_N_ZERO,   S_CHECK,  1'b0};
      S_SUM:      w = '{OP_SUM,      C_J_EQ_N,   S_CHECK,  1'b1};
      S_CHECK:    w = '{OP_CHECK,    C_ERR,      S_EMIT,   1'b0};
      S_SPLIT:    w = '{OP_NEXT,     C_LAST,     S_LAST,   1'b0};
      S_WALK:     w = '{OP_WALK,     C_FOUND,    S_DIFF,   1'b1};
      S_DIFF:     w = '{OP_DIFF,     C_NEVER,    S_FETCH,  1'b0};
      S_MUL:      w = '{OP_MUL,      C_NEVER,    S_FETCH,  1'b0};
      S_DIV_INIT: w = '{OP_DIV_INIT, C_NEVER,    S_FETCH,  1'b0};
      S_DIV:      w = '{OP_DIV,      C_DIV_LAST, S_FIN,    1'b1};
      S_FIN:      w = '{OP_FIN,      C_ALWAYS,   S_EMIT,   1'b0};
      S_LAST:     w = '{OP_LAST,     C_NEVER,    S_FETCH,  1'b0};
      S_EMIT:     w = '{OP_NOP,      C_OUT_FREE, S_FETCH,  1'b1};
      default:    w = '{OP_NOP,      C_ALWAYS,   S_FETCH,  1'b0};
    endcase
    return w;
  endfunction

endpackage

/* sv/piecewise_linear_table_generator.sv */
// flow: a load goes from accept through the route step to emit; a sample sums the
// segment lengths in use, checks sum and index, walks to the segment hit, then forms
// difference, product, 16-step quotient and result; an error goes to emit after the
// check, the last table index emits the point value at the segment count; one item at
// a time: the next item can be accepted the cycle after the result enters the output register
// reset: synchronous rst resets sequencer, output valid and config registers
`include "piecewise_linear_table_generator_defines.svh"

module piecewise_linear_table_generator #(
  parameter int MAX_POINTS = pltg_pkg::MAX_POINTS_DEF,
  parameter int INDEX_BITS = pltg_pkg::INDEX_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // config write port
  input  logic                               cfg_we,
  input  logic [pltg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pltg_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input beats
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pltg_pkg::S_DATA_W-1:0]      s_tdata,  // slot, point_value, segment_length, sample_index
  input  logic [pltg_pkg::CMD_W-1:0]         s_tuser,  // cmd
  // result beats
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pltg_pkg::M_DATA_W-1:0]      m_tdata,  // sample
  output logic [pltg_pkg::STAT_W-1:0]        m_tuser   // status
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int SUM_W = pltg_pkg::LEN_W + AW;
  localparam int CW    = ((SUM_W > INDEX_BITS) ? SUM_W : INDEX_BITS) + 1;
  localparam int VW    = pltg_pkg::VAL_W;
  localparam int LW    = pltg_pkg::LEN_W;

  // config registers
  logic [pltg_pkg::CNT_W-1:0] segment_count;
  logic [pltg_pkg::TS_W-1:0]  table_size;

  // sequencer
  pltg_pkg::step_t  pc, pc_next;
  pltg_pkg::ucode_t uc;
  logic             flag;

  // breakpoint stores
  logic [VW-1:0] pv_mem  [MAX_POINTS];
  logic [LW-1:0] len_mem [MAX_POINTS];
  logic [VW-1:0] rd_pv;
  logic [LW-1:0] rd_len;

  // datapath registers
  logic                          cmd_r;
  logic [INDEX_BITS-1:0]         k_r;
  logic [AW-1:0]                 n_r;
  logic [AW-1:0]                 j;
  logic [SUM_W-1:0]              acc;
  logic [VW-1:0]                 a_r;
  logic [LW-1:0]                 off_r;
  logic [LW-1:0]                 div_len;
  logic                          d_neg;
  logic [VW-1:0]                 d_mag;
  logic [pltg_pkg::PROD_W-1:0]   prod;
  logic [LW-1:0]                 rem;
  logic [VW-1:0]                 dq;
  logic [pltg_pkg::DIV_CNT_W-1:0] cnt;
  logic [VW-1:0]                 res_r;
  pltg_pkg::status_t             status_r;

  // combinational helpers
  logic                   s_accept;
  logic                   out_free;
  logic [AW+3:0]          slot_ext;
  logic                   slot_ok;
  logic [AW-1:0]          waddr;
  logic [INDEX_BITS+15:0] idx_ext;
  logic [INDEX_BITS-1:0]  idx;
  logic [AW-1:0]          n_next;
  logic                   sum_bad;
  logic                   idx_bad;
  logic                   is_last;
  logic                   found;
  logic [CW-1:0]          seg_end;
  logic [CW-1:0]          off_full;
  logic [VW:0]            diff;
  logic [VW:0]            diff_abs;
  logic [LW:0]            div_t;
  logic                   div_ge;
  logic [LW:0]            div_sub;

  // handshakes
  assign s_tready = (pc == pltg_pkg::S_FETCH);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // input field decode
  assign slot_ext = {{AW{1'b0}}, s_tdata[pltg_pkg::SLOT_LSB +: pltg_pkg::SLOT_W]};
  assign slot_ok  = slot_ext < (AW + 4)'(MAX_POINTS);
  assign waddr    = slot_ext[AW-1:0];
  assign idx_ext  = {{INDEX_BITS{1'b0}}, s_tdata[pltg_pkg::IDX_LSB +: pltg_pkg::IDX_W]};
  assign idx      = idx_ext[INDEX_BITS-1:0];
  assign n_next   = (int'(segment_count) > MAX_POINTS - 1) ? AW'(MAX_POINTS - 1)
                                                            : AW'(segment_count);

  // range checks and segment search
  assign sum_bad  = CW'(acc) != CW'(table_size);
  assign idx_bad  = CW'(k_r) >= CW'(table_size);
  assign is_last  = CW'(k_r) == (CW'(table_size) - CW'(1));
  assign seg_end  = CW'(acc) + CW'(rd_len);
  assign found    = (rd_len != '0) && (CW'(k_r) < seg_end);
  assign off_full = CW'(k_r) - CW'(acc);

  // slope and divider step
  assign diff     = {rd_pv[VW-1], rd_pv} - {a_r[VW-1], a_r};
  assign diff_abs = diff[VW] ? (~diff + (VW + 1)'(1)) : diff;
  assign div_t    = {rem, dq[VW-1]};
  assign div_ge   = div_t >= {1'b0, div_len};
  assign div_sub  = div_t - {1'b0, div_len};

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= pltg_pkg::SEGMENT_COUNT_RST;
      table_size    <= pltg_pkg::TABLE_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pltg_pkg::REG_SEGMENT_COUNT: segment_count <= cfg_data[pltg_pkg::CNT_W-1:0];
        pltg_pkg::REG_TABLE_SIZE:    table_size    <= cfg_data[pltg_pkg::TS_W-1:0];
        default: ;
      endcase
    end
  end

  // control word fetch and condition select
  always_comb begin
    uc = pltg_pkg::ucode(pc);
    case (uc.cond)
      pltg_pkg::C_NEVER:    flag = 1'b0;
      pltg_pkg::C_ALWAYS:   flag = 1'b1;
      pltg_pkg::C_IN_ACC:   flag = s_accept;
      pltg_pkg::C_LOAD:     flag = (cmd_r == pltg_pkg::CMD_LOAD);
      pltg_pkg::C_N_ZERO:   flag = (n_r == '0);
      pltg_pkg::C_J_EQ_N:   flag = (j == n_r);
      pltg_pkg::C_ERR:      flag = sum_bad || idx_bad;
      pltg_pkg::C_LAST:     flag = is_last;
      pltg_pkg::C_FOUND:    flag = found;
      pltg_pkg::C_DIV_LAST: flag = (cnt == pltg_pkg::DIV_CNT_W'(pltg_pkg::DIV_STEPS - 1));
      pltg_pkg::C_OUT_FREE: flag = out_free;
      default:              flag = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (flag) begin
      pc_next = uc.target;
    end else if (uc.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pltg_pkg::step_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pltg_pkg::S_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  // breakpoint stores, registered read at j
  always_ff @(posedge clk) begin
    if (s_accept && (s_tuser == pltg_pkg::CMD_LOAD) && slot_ok) begin
      pv_mem[waddr]  <= s_tdata[pltg_pkg::VAL_LSB +: VW];
      len_mem[waddr] <= s_tdata[pltg_pkg::LEN_LSB +: LW];
    end
    rd_pv  <= pv_mem[j];
    rd_len <= len_mem[j];
  end

  // datapath driven by the control word
  always_ff @(posedge clk) begin
    case (uc.op)
      pltg_pkg::OP_FETCH: begin
        if (s_accept) begin
          cmd_r    <= s_tuser;
          k_r      <= idx;
          n_r      <= n_next;
          j        <= '0;
          acc      <= '0;
          res_r    <= '0;
          status_r <= pltg_pkg::ST_OK;
        end
      end
      pltg_pkg::OP_NEXT: begin
        j <= j + AW'(1);
      end
      pltg_pkg::OP_SUM: begin
        acc <= acc + SUM_W'(rd_len);
        j   <= j + AW'(1);
      end
      pltg_pkg::OP_CHECK: begin
        if (sum_bad) begin
          status_r <= pltg_pkg::ST_SUM;
        end else if (idx_bad) begin
          status_r <= pltg_pkg::ST_RANGE;
        end else begin
          status_r <= pltg_pkg::ST_OK;
        end
        res_r <= '0;
        j     <= is_last ? n_r : '0;
        acc   <= '0;
      end
      pltg_pkg::OP_WALK: begin
        if (found) begin
          a_r     <= rd_pv;
          off_r   <= off_full[LW-1:0];
          div_len <= rd_len;
        end else begin
          acc <= acc + SUM_W'(rd_len);
          j   <= j + AW'(1);
        end
      end
      pltg_pkg::OP_DIFF: begin
        d_neg <= diff[VW];
        d_mag <= diff_abs[VW-1:0];
      end
      pltg_pkg::OP_MUL: begin
        prod <= pltg_pkg::PROD_W'(d_mag) * pltg_pkg::PROD_W'(off_r);
      end
      pltg_pkg::OP_DIV_INIT: begin
        rem <= prod[pltg_pkg::PROD_W-1 -: LW];
        dq  <= prod[VW-1:0];
        cnt <= '0;
      end
      pltg_pkg::OP_DIV: begin
        rem <= div_ge ? div_sub[LW-1:0] : div_t[LW-1:0];
        dq  <= {dq[VW-2:0], div_ge};
        cnt <= cnt + pltg_pkg::DIV_CNT_W'(1);
      end
      pltg_pkg::OP_FIN: begin
        res_r <= d_neg ? (a_r - dq) : (a_r + dq);
      end
      pltg_pkg::OP_LAST: begin
        res_r <= rd_pv;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pc == pltg_pkg::S_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pc == pltg_pkg::S_EMIT && out_free) begin
      m_tdata <= pltg_pkg::M_DATA_W'(res_r);
      m_tuser <= status_r;
    end
  end

  // checks
  `PLTG_ASSERT(a_div_rem_lt_len, pc == pltg_pkg::S_DIV, rem < div_len)
  `PLTG_ASSERT(a_walk_in_range, pc == pltg_pkg::S_WALK, j <= n_r)
  `PLTG_ASSERT(a_load_zero, pc == pltg_pkg::S_EMIT && cmd_r == pltg_pkg::CMD_LOAD, res_r == '0 && status_r == pltg_pkg::ST_OK)
  `PLTG_ASSERT(a_err_zero, pc == pltg_pkg::S_EMIT && status_r != pltg_pkg::ST_OK, res_r == '0)
  `PLTG_ASSERT_NEXT(a_emit_valid, pc == pltg_pkg::S_EMIT && out_free, m_tvalid && pc == pltg_pkg::S_FETCH)

endmodule
